[rtl/isc_pkg.sv]
// Shared types and constants for the interpolated sine and cosine core.
package isc_pkg;

	localparam int TABLE_ENTRIES = 4097;
	localparam int SLOT_W        = 13;
	localparam int TURN_W        = 24;
	localparam int ENTRY_W       = 22;
	localparam int FRAC_W        = 10;
	localparam int WORD_W        = 32;
	localparam int RESULT_W      = 18;

	typedef logic [1:0]          req_kind_t;
	typedef logic [TURN_W-1:0]   turn_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [ENTRY_W-1:0]  entry_t;
	typedef logic [FRAC_W-1:0]   frac_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [RESULT_W-1:0] result_t;

	localparam req_kind_t REQ_SINE   = 2'd0;
	localparam req_kind_t REQ_COSINE = 2'd1;
	localparam req_kind_t REQ_WRITE  = 2'd2;

	localparam turn_t QUARTER_TURN = 24'h400000;
	localparam turn_t HALF_TURN    = 24'h800000;

endpackage

[rtl/isc_ram.sv]
// Generic RAM: one write port, two registered read ports.
module isc_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 4097
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

[rtl/interpolated_sine_cosine_core.sv]
// Throughput: one item per cycle while res_stall does not hold the output; four
// stages (angle offset, fold and table read, multiply, sum and sign) each take a
// new item whenever the next one moves.
// Table writes give no result and leave the pipeline after the first stage.
// Reset clears the stage valid bits only; table entries are undefined until written.
module interpolated_sine_cosine_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  isc_pkg::req_kind_t req_type,
	input  isc_pkg::turn_t   angle,
	input  isc_pkg::slot_t   table_slot,
	input  isc_pkg::word_t   table_word,
	output logic             res_valid,
	input  logic             res_stall,
	output isc_pkg::result_t result_value
);
	import isc_pkg::*;

	// Per-stage advance enables
	logic en_s1, en_s2, en_s3, en_s4;

	logic   valid_s1, write_s1;
	turn_t  turn_s1;
	slot_t  slot_s1;
	entry_t entry_s1;

	logic   valid_s2, neg_s2;
	frac_t  frac_s2;
	entry_t lo_s2, hi_s2;

	logic                   valid_s3, neg_s3;
	entry_t                 lo_s3;
	logic [WORD_W-1:0]      prod_s3;

	logic    valid_s4;
	result_t result_s4;

	logic  accept, take_in;
	turn_t fold_turn;
	logic  fold_neg;
	slot_t rd_lo, rd_hi;
	frac_t fold_frac;
	logic  ram_we;

	logic signed [ENTRY_W:0]   diff;
	logic signed [ENTRY_W+FRAC_W+1:0] prod_full;
	logic [WORD_W-1:0]         sum;
	logic [RESULT_W-1:0]       mag;

	assign en_s4 = !valid_s4 || !res_stall;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign req_stall = !en_s1;

	assign accept  = req_valid && !req_stall;
	assign take_in = accept && (req_type == REQ_SINE || req_type == REQ_COSINE ||
		req_type == REQ_WRITE);

	// Fold into the first quadrant; the top bit left over marks the lower half-turn
	always_comb begin
		fold_turn = turn_s1[22] ? (HALF_TURN - turn_s1) : turn_s1;
		fold_neg  = fold_turn[23];
		fold_frac = fold_turn[FRAC_W-1:0];
		rd_lo     = fold_turn[22:FRAC_W];
		rd_hi     = (fold_frac != '0) ? rd_lo + SLOT_W'(1) : rd_lo;
	end

	assign ram_we = valid_s1 && write_s1 && en_s2 && (slot_s1 < SLOT_W'(TABLE_ENTRIES));

	isc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk       (clk),
		.wr_en     (ram_we),
		.wr_addr   (slot_s1),
		.wr_data   (entry_s1),
		.rd_en     (en_s2),
		.rd_addr_a (rd_lo),
		.rd_addr_b (rd_hi),
		.rd_data_a (lo_s2),
		.rd_data_b (hi_s2)
	);

	always_comb begin
		diff      = $signed({1'b0, hi_s2}) - $signed({1'b0, lo_s2});
		prod_full = (ENTRY_W+FRAC_W+2)'(diff) *
			(ENTRY_W+FRAC_W+2)'($signed({1'b0, frac_s2}));
		sum       = {lo_s3, {FRAC_W{1'b0}}} + prod_s3;
		mag       = {1'b0, sum[WORD_W-1:15]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= take_in;
			if (en_s2) valid_s2 <= valid_s1 && !write_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			write_s1 <= (req_type == REQ_WRITE);
			turn_s1  <= (req_type == REQ_COSINE) ? angle + QUARTER_TURN : angle;
			slot_s1  <= table_slot;
			entry_s1 <= table_word[WORD_W-1:FRAC_W];
		end
		if (en_s2) begin
			neg_s2  <= fold_neg;
			frac_s2 <= fold_frac;
		end
		if (en_s3) begin
			neg_s3  <= neg_s2;
			lo_s3   <= lo_s2;
			prod_s3 <= prod_full[WORD_W-1:0];
		end
		if (en_s4) begin
			result_s4 <= neg_s3 ? (RESULT_W'(0) - mag) : mag;
		end
	end

	assign res_valid    = valid_s4;
	assign result_value = result_s4;

	// Input stalls only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && res_stall))
		else $error("input stalled with a free stage");

	// Folded angle never addresses past the last table entry
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !write_s1) |-> (rd_hi < SLOT_W'(TABLE_ENTRIES)))
		else $error("table read beyond last entry");

	// A held multiply stage keeps its item
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en_s4) |=> (valid_s3 && $stable(prod_s3) && $stable(lo_s3)))
		else $error("multiply stage lost its item");

	// Table writes never reach the read stages
	a_write_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && write_s1 && en_s2) |=> !valid_s2)
		else $error("write request entered the read pipeline");

endmodule

[bench/interpolated_sine_cosine_core_test.sv]
// Self-checking testbench for the interpolated sine and cosine core.
module interpolated_sine_cosine_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import isc_pkg::*;

	localparam req_kind_t REQ_UNUSED   = 2'd3;
	localparam int        RANDOM_ITEMS = 1100;
	localparam int        CYCLE_LIMIT  = 200000;
	localparam int        TAIL_CYCLES  = 8;
	localparam int        SLOT_SPAN    = 1 << SLOT_W;

	// Keeps a copy of the quarter-sine table and the values still owed by the core.
	class sine_cosine_checker;
		entry_t  table_copy[TABLE_ENTRIES];
		result_t awaited_values[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function entry_t entry_at(int unsigned s);
			return (s < TABLE_ENTRIES) ? table_copy[s] : '0;
		endfunction

		function result_t fold_and_interpolate(turn_t t);
			turn_t       a;
			logic        negate;
			int unsigned s;
			frac_t       f;
			logic [31:0] lo, hi, acc;
			result_t     mag;
			a = t;
			// fold into the first quadrant, remember the lower half-turn
			if ((a & QUARTER_TURN) != 0)
				a = HALF_TURN - a;
			negate = a >= HALF_TURN;
			if (negate)
				a = a - HALF_TURN;
			s = 32'(a >> FRAC_W);
			f = a[FRAC_W-1:0];
			lo = 32'(entry_at(s));
			hi = (f != 0) ? 32'(entry_at(s + 1)) : lo;
			acc = (lo << FRAC_W) + (hi - lo) * {22'd0, f};
			mag = result_t'(acc >> 15);
			return negate ? result_t'(-mag) : mag;
		endfunction

		function void note_request(req_kind_t k, turn_t a, slot_t s, word_t w);
			case (k)
			REQ_SINE: awaited_values.push_back(fold_and_interpolate(a));
			REQ_COSINE: awaited_values.push_back(fold_and_interpolate(a + QUARTER_TURN));
			REQ_WRITE: begin
				if (s < TABLE_ENTRIES)
					table_copy[s] = w[WORD_W-1:FRAC_W];
			end
			default: ;
			endcase
		endfunction

		task check_result(result_t v);
			result_t want;
			if (awaited_values.size() == 0) begin
				report($sformatf("result %0d arrived with none expected", $signed(v)));
			end else begin
				want = awaited_values.pop_front();
				if (v !== want)
					report($sformatf("result_value %0d, expected %0d",
						$signed(v), $signed(want)));
			end
		endtask
	endclass

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      req_valid  = 1'b0;
	logic      req_stall;
	req_kind_t req_type   = REQ_SINE;
	turn_t     angle      = '0;
	slot_t     table_slot = '0;
	word_t     table_word = '0;
	logic      res_valid;
	logic      res_stall  = 1'b0;
	result_t   result_value;

	sine_cosine_checker book = new();
	bit          written[TABLE_ENTRIES];
	int unsigned written_slots[$];
	bit          calm = 1'b0;
	bit          paused = 1'b0;
	int          items_sent = 0;
	int          cycles = 0;
	int          stall_left = 0;

	interpolated_sine_cosine_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.angle        (angle),
		.table_slot   (table_slot),
		.table_word   (table_word),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_value (result_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[interpolated_sine_cosine_core] ERROR");
			$finish;
		end
	end

	// Check each accepted result, then hold off the next one for a random while.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else if (res_valid === 1'b1 && !res_stall) begin
			book.check_result(result_value);
			stall_left = calm ? 0 : $urandom_range(0, 5);
			res_stall <= (stall_left != 0);
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= (stall_left != 0);
		end
	end

	task automatic send_item(req_kind_t k, turn_t a, slot_t s, word_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= k;
		angle      <= a;
		table_slot <= s;
		table_word <= w;
		do begin
			@(posedge clk);
		end while (req_stall !== 1'b0);
		book.note_request(k, a, s, w);
	endtask

	task automatic write_entry(slot_t s, word_t w);
		send_item(REQ_WRITE, turn_t'($urandom), s, w);
		if (s < TABLE_ENTRIES && !written[s]) begin
			written[s] = 1'b1;
			written_slots.push_back(32'(s));
		end
		items_sent++;
	endtask

	task automatic request_value(req_kind_t k, turn_t a);
		send_item(k, a, slot_t'($urandom), $urandom);
		items_sent++;
	endtask

	// Pick an angle whose table neighbors are all loaded, in a random quadrant.
	task automatic request_known_value();
		int unsigned s;
		frac_t       f;
		turn_t       folded, t;
		int          q;
		req_kind_t   k;
		s = written_slots[$urandom_range(0, written_slots.size() - 1)];
		f = (s + 1 < TABLE_ENTRIES && written[s + 1]) ? frac_t'($urandom) : '0;
		if ($urandom_range(0, 7) == 0)
			f = '0;
		folded = turn_t'(s << FRAC_W) | turn_t'(f);
		q = $urandom_range(0, 3);
		if (folded == 0 && q % 2 == 1)
			q--;
		if (folded == QUARTER_TURN && q % 2 == 0)
			q++;
		case (q)
		0: t = folded;
		1: t = HALF_TURN - folded;
		2: t = HALF_TURN + folded;
		default: t = -folded;
		endcase
		k = ($urandom_range(0, 1) != 0) ? REQ_COSINE : REQ_SINE;
		request_value(k, (k == REQ_COSINE) ? t - QUARTER_TURN : t);
	endtask

	task automatic wait_for_results();
		while (book.awaited_values.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned s;
		int          pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load a few entries at the edges of the table and around the middle
		write_entry(slot_t'(0), 32'h0000_0000);
		write_entry(slot_t'(1), 32'hFFFF_FFFF);
		write_entry(slot_t'(TABLE_ENTRIES - 1), 32'hFFFF_FFFF);
		write_entry(slot_t'(TABLE_ENTRIES - 2), $urandom);
		write_entry(slot_t'(2048), 32'hFFFF_FC00);
		write_entry(slot_t'(2049), 32'h0000_03FF);
		// writes past the table and the unused request type are dropped
		send_item(REQ_WRITE, '0, slot_t'(TABLE_ENTRIES), $urandom);
		send_item(REQ_WRITE, '1, '1, $urandom);
		send_item(REQ_UNUSED, turn_t'($urandom), slot_t'($urandom), $urandom);

		request_value(REQ_SINE, 24'h000000);
		request_value(REQ_SINE, 24'h0003FF);
		request_value(REQ_SINE, QUARTER_TURN);
		request_value(REQ_COSINE, 24'h000000);
		request_value(REQ_SINE, HALF_TURN);
		request_value(REQ_SINE, 24'hC00000);
		request_value(REQ_SINE, 24'hFFFFFF);
		request_value(REQ_COSINE, 24'hFFFFFF);
		request_value(REQ_COSINE, 24'hC00000);
		request_value(REQ_SINE, 24'h200200);
		request_value(REQ_SINE, 24'hA00200);
		request_value(REQ_COSINE, 24'h7FFC00);
		write_entry(slot_t'(0), 32'hFFFF_FFFF);
		request_value(REQ_SINE, HALF_TURN);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
				// drain the pipeline completely once mid-run
				req_valid <= 1'b0;
				@(posedge clk);
				wait_for_results();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				send_item(REQ_UNUSED, turn_t'($urandom), slot_t'($urandom), $urandom);
			end else if (pick < 5) begin
				send_item(REQ_WRITE, turn_t'($urandom),
					slot_t'($urandom_range(TABLE_ENTRIES, SLOT_SPAN - 1)), $urandom);
			end else if (pick < 35) begin
				s = $urandom_range(0, TABLE_ENTRIES - 1);
				write_entry(slot_t'(s), $urandom);
				if (pick < 20 && s < TABLE_ENTRIES - 1)
					write_entry(slot_t'(s + 1), $urandom);
			end else begin
				request_known_value();
			end
		end

		req_valid <= 1'b0;
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.errors == 0)
			$display("[interpolated_sine_cosine_core] OK");
		else
			$display("[interpolated_sine_cosine_core] ERROR");
		$finish;
	end

endmodule
